### design/utf8w_pkg.sv
`timescale 1ns / 1ps

package utf8w_pkg;

    localparam int TABLE_ENTRIES = 192;
    localparam int FRACTION_BITS = 6;
    localparam int SUM_BITS      = 32;
    localparam int WIDTH_BITS    = 27;
    localparam int IDX_BITS      = 8;
    localparam int ADV_BITS      = 16;
    localparam int ACC_BITS      = SUM_BITS + 2;

    // table slot of '?', used for invalid leads and cut-off sequences
    localparam logic [IDX_BITS-1:0] QMARK_ENTRY = 8'd31;

    typedef logic [SUM_BITS-1:0] sum_t;

    // decoded take list of one byte
    typedef struct packed {
        logic [1:0]          q_cnt;
        logic                a_en;
        logic [IDX_BITS-1:0] a_idx;
        logic                b_en;
        logic [IDX_BITS-1:0] b_idx;
        logic                last;
    } dec_t;

    // advances fetched for one byte
    typedef struct packed {
        logic [1:0]          q_cnt;
        logic [ADV_BITS-1:0] q_val;
        logic                a_en;
        logic [ADV_BITS-1:0] a_val;
        logic                b_en;
        logic [ADV_BITS-1:0] b_val;
        logic                last;
    } acc_in_t;

    typedef struct packed {
        sum_t sum;
        logic sat;
    } total_t;

endpackage

### design/utf8_text_width_measure_unit.sv
`timescale 1ns / 1ps

// UTF-8 line width measurement.
// Input stream (s_*): one beat per byte. s_tuser selects the beat kind:
//   0 = text byte in s_tdata[7:0], s_tlast marks the last byte of the string;
//   1 = advance table load, slot s_tdata[15:8], Q10.6 value s_tdata[31:16]
//       (slots 192 and up are dropped, s_tlast is ignored).
// Output stream (m_*): one beat per string, sent for the s_tlast text byte,
//   carrying the rounded width in pixels and the saturation flag.
// Throughput: one beat per clock on the input while the output is not stalled.
//   Five register stages (input, decode, table read, accumulate, round) with
//   per-stage valids; the accumulator adds to its registered sum combinationally.
// Result path: the last byte of a string moves from the input register through the
//   decode, table read and final sum registers to the rounded result beat.
// Stall: while m_tready is low the held result stays put and new bytes keep
//   flowing until the pipeline fills; a load skips the decode stage but waits
//   while a stalled text byte there still has its table read to do.
// Reset: clears all stage valids and the decode and sum state. The advance
//   table is not cleared and must be loaded before text is measured.
module utf8_text_width_measure_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // text_byte[7:0], entry_index[15:8], advance_value[31:16]
    input  logic        s_tuser,   // cmd
    input  logic        s_tlast,   // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // width_px[26:0], saturated[27], zero pad[31:28]
);
    import utf8w_pkg::*;

    localparam int RND_BITS = SUM_BITS + WIDTH_BITS + 1;
    localparam logic [RND_BITS-1:0] RND_HALF = RND_BITS'((2 ** FRACTION_BITS) / 2);

    // stage 1: input register
    logic                v1_reg;
    logic                cmd1_reg;
    logic [7:0]          byte1_reg;
    logic                last1_reg;
    logic [IDX_BITS-1:0] idx1_reg;
    logic [ADV_BITS-1:0] val1_reg;

    // stage 2: decoded takes
    logic v2_reg;
    dec_t dec, dec2_reg;

    // stage 3: fetched advances
    logic    v3_reg;
    acc_in_t acc3_reg;
    total_t  total;

    // stage 4: final sum of a string
    logic   v4_reg;
    total_t tot4_reg;

    // output register
    logic                  m_valid_reg;
    logic [WIDTH_BITS-1:0] px_reg;
    logic                  msat_reg;
    logic [RND_BITS-1:0]   rnd;

    // advance table, plus a copy of the '?' slot for every '?' glyph
    logic [ADV_BITS-1:0] table_mem [TABLE_ENTRIES];
    logic [ADV_BITS-1:0] q_adv_reg;

    logic out_free, free4, free3, free2, free1;
    logic move4, move3, move2, move1;

    always_comb
    begin
        out_free = !m_valid_reg || m_tready;
        move4    = v4_reg && out_free;
        free4    = !v4_reg || out_free;
        // only a string end needs room in stage 4
        move3    = v3_reg && (!acc3_reg.last || free4);
        free3    = !v3_reg || move3;
        move2    = v2_reg && free3;
        free2    = !v2_reg || move2;
        // a load must not overtake a text byte still waiting for its table read
        move1    = v1_reg && free2;
        free1    = !v1_reg || move1;
    end

    assign s_tready = free1;

    utf8w_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (move1 && !cmd1_reg),
        .text_byte (byte1_reg),
        .last      (last1_reg),
        .dec       (dec)
    );

    utf8w_accum u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (move3),
        .din   (acc3_reg),
        .total (total)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (free1)
                v1_reg <= s_tvalid;
            if (free2)
                v2_reg <= v1_reg && !cmd1_reg;
            if (free3)
                v3_reg <= v2_reg;
            if (free4)
                v4_reg <= move3 && acc3_reg.last;
            if (out_free)
                m_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd1_reg  <= s_tuser;
            byte1_reg <= s_tdata[7:0];
            last1_reg <= s_tlast;
            idx1_reg  <= s_tdata[15:8];
            val1_reg  <= s_tdata[31:16];
        end
    end

    // table writes
    always_ff @(posedge clk)
    begin
        if (move1 && cmd1_reg && (idx1_reg < TABLE_ENTRIES))
        begin
            table_mem[idx1_reg] <= val1_reg;
            if (idx1_reg == QMARK_ENTRY)
                q_adv_reg <= val1_reg;
        end
    end

    // table reads, two ports, registered
    always_ff @(posedge clk)
    begin
        if (move2)
        begin
            acc3_reg.q_cnt <= dec2_reg.q_cnt;
            acc3_reg.q_val <= q_adv_reg;
            acc3_reg.a_en  <= dec2_reg.a_en;
            acc3_reg.a_val <= table_mem[dec2_reg.a_idx];
            acc3_reg.b_en  <= dec2_reg.b_en;
            acc3_reg.b_val <= table_mem[dec2_reg.b_idx];
            acc3_reg.last  <= dec2_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move1 && !cmd1_reg)
            dec2_reg <= dec;
        if (move3 && acc3_reg.last)
            tot4_reg <= total;
        if (move4)
        begin
            px_reg   <= rnd[WIDTH_BITS-1:0];
            msat_reg <= tot4_reg.sat;
        end
    end

    // round half up to whole pixels
    assign rnd = (RND_BITS'(tot4_reg.sum) + RND_HALF) >> FRACTION_BITS;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, msat_reg, px_reg};

    a_load_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && cmd1_reg && free2) |-> s_tready)
        else $error("table load held in input stage");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(v4_reg))
        else $error("result beat without a finished string");

    a_stall_holds_end: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && !out_free) |-> !(move3 && acc3_reg.last))
        else $error("string end overran a stalled final stage");

endmodule

### design/utf8w_decode.sv
`timescale 1ns / 1ps

module utf8w_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        text_byte,
    input  logic              last,
    output utf8w_pkg::dec_t   dec
);
    import utf8w_pkg::*;

    localparam int CP_BITS = 21;
    localparam logic [7:0]         CP_QMARK = 8'h3F;
    localparam logic [CP_BITS-1:0] CP_LF    = 21'd10;
    localparam logic [CP_BITS-1:0] CP_CR    = 21'd13;

    logic [2:0] seq_reg, seq_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       le_reg, le_next;
    logic [7:0] p0_reg, p0_next;
    logic [7:0] p1_reg, p1_next;
    logic [7:0] p2_reg, p2_next;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        if (!b[7])
            return 3'd1;
        else if (b[7:5] == 3'b110)
            return 3'd2;
        else if (b[7:4] == 4'b1110)
            return 3'd3;
        else if (b[7:3] == 5'b11110)
            return 3'd4;
        else
            return 3'd0;
    endfunction

    function automatic logic [CP_BITS-1:0] qmark();
        return {13'd0, CP_QMARK};
    endfunction

    // byte decoded on its own at the end of a tail
    function automatic logic [CP_BITS-1:0] single_cp(input logic [7:0] b);
        if (lead_len(b) == 3'd1)
            return {13'd0, b};
        else
            return qmark();
    endfunction

    function automatic logic [CP_BITS-1:0] asm2(input logic [7:0] b0, input logic [7:0] b1);
        return {10'd0, b0[4:0], b1[5:0]};
    endfunction

    function automatic logic [CP_BITS-1:0] asm3(input logic [7:0] b0, input logic [7:0] b1,
                                                input logic [7:0] b2);
        return {5'd0, b0[3:0], b1[5:0], b2[5:0]};
    endfunction

    function automatic logic [CP_BITS-1:0] asm4(input logic [7:0] b0, input logic [7:0] b1,
                                                input logic [7:0] b2, input logic [7:0] b3);
        return {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
    endfunction

    function automatic logic [IDX_BITS-1:0] entry_of(input logic [CP_BITS-1:0] cp);
        if (cp inside {[32:127]})
            return IDX_BITS'(cp - 21'd32);
        else if (cp inside {[160:255]})
            return IDX_BITS'(cp - 21'd64);
        else
            return '0;
    endfunction

    always_comb
    begin
        logic [2:0]               lead;
        logic [2:0]               slot_v;
        logic [CP_BITS-1:0]       slot_cp [3];
        logic [2:0]               eff;
        logic [2:0]               isq;
        logic [IDX_BITS-1:0]      idx [3];
        logic                     le;

        seq_next = seq_reg;
        cnt_next = cnt_reg;
        p0_next  = p0_reg;
        p1_next  = p1_reg;
        p2_next  = p2_reg;
        slot_v   = '0;
        for (int i = 0; i < 3; i++)
        begin
            slot_cp[i] = '0;
        end
        lead = lead_len(text_byte);

        if (!le_reg)
        begin
            if (seq_reg == 3'd0)
            begin
                case (lead)
                    3'd0:
                    begin
                        slot_v[0]  = 1'b1;
                        slot_cp[0] = qmark();
                    end
                    3'd1:
                    begin
                        slot_v[0]  = 1'b1;
                        slot_cp[0] = {13'd0, text_byte};
                    end
                    default:
                    begin
                        p0_next  = text_byte;
                        cnt_next = 2'd1;
                        seq_next = lead;
                        // lone lead at end of string
                        if (last)
                        begin
                            slot_v[0]  = 1'b1;
                            slot_cp[0] = qmark();
                        end
                    end
                endcase
            end
            else if ({1'b0, cnt_reg} == seq_reg - 3'd1)
            begin
                // sequence completes with this byte
                slot_v[0] = 1'b1;
                case (seq_reg)
                    3'd3:    slot_cp[0] = asm3(p0_reg, p1_reg, text_byte);
                    3'd4:    slot_cp[0] = asm4(p0_reg, p1_reg, p2_reg, text_byte);
                    default: slot_cp[0] = asm2(p0_reg, text_byte);
                endcase
                seq_next = 3'd0;
                cnt_next = 2'd0;
            end
            else
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd1)
                    p1_next = text_byte;
                else
                    p2_next = text_byte;
                // cut off: lead is '?', the tail is parsed again
                if (last)
                begin
                    slot_v[0]  = 1'b1;
                    slot_cp[0] = qmark();
                    if (cnt_reg == 2'd1)
                    begin
                        slot_v[1]  = 1'b1;
                        slot_cp[1] = single_cp(text_byte);
                    end
                    else
                    begin
                        slot_v[1] = 1'b1;
                        case (lead_len(p1_reg))
                            3'd1:
                            begin
                                slot_cp[1] = {13'd0, p1_reg};
                                slot_v[2]  = 1'b1;
                                slot_cp[2] = single_cp(text_byte);
                            end
                            3'd2:
                            begin
                                slot_cp[1] = asm2(p1_reg, text_byte);
                            end
                            default:
                            begin
                                slot_cp[1] = qmark();
                                slot_v[2]  = 1'b1;
                                slot_cp[2] = single_cp(text_byte);
                            end
                        endcase
                    end
                end
            end
        end

        // CR is dropped, LF closes the line for the rest of the string
        le = le_reg;
        for (int i = 0; i < 3; i++)
        begin
            eff[i] = slot_v[i] && !le && (slot_cp[i] != CP_CR) && (slot_cp[i] != CP_LF);
            if (slot_v[i] && !le && (slot_cp[i] == CP_LF))
                le = 1'b1;
            idx[i] = entry_of(slot_cp[i]);
            isq[i] = (idx[i] == QMARK_ENTRY);
        end

        le_next = le;
        if (last)
        begin
            seq_next = 3'd0;
            cnt_next = 2'd0;
            le_next  = 1'b0;
        end

        dec.q_cnt = 2'(eff[0] && isq[0]) + 2'(eff[1] && isq[1]) + 2'(eff[2] && isq[2]);
        if (eff[0] && !isq[0])
        begin
            dec.a_en  = 1'b1;
            dec.a_idx = idx[0];
        end
        else
        begin
            dec.a_en  = eff[1] && !isq[1];
            dec.a_idx = idx[1];
        end
        dec.b_en  = eff[2] && !isq[2];
        dec.b_idx = idx[2];
        dec.last  = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= 3'd0;
            cnt_reg <= 2'd0;
            le_reg  <= 1'b0;
        end
        else if (step)
        begin
            seq_reg <= seq_next;
            cnt_reg <= cnt_next;
            le_reg  <= le_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg != 3'd0) |-> (cnt_reg != 2'd0) && ({1'b0, cnt_reg} < seq_reg))
        else $error("pending count out of range for open sequence");

    a_le_closed: assert property (@(posedge clk) disable iff (!rst_n)
        le_reg |-> (seq_reg == 3'd0) && (cnt_reg == 2'd0))
        else $error("sequence open after line end");

endmodule

### design/utf8w_accum.sv
`timescale 1ns / 1ps

module utf8w_accum (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  utf8w_pkg::acc_in_t  din,
    output utf8w_pkg::total_t   total
);
    import utf8w_pkg::*;

    localparam logic [ACC_BITS-1:0] SUM_MAX_ACC = {2'b00, {SUM_BITS{1'b1}}};

    sum_t sum_reg;
    logic sat_reg;

    always_comb
    begin
        logic [ACC_BITS-1:0] qx;
        logic [ACC_BITS-1:0] q_part;
        logic [ACC_BITS-1:0] a_part;
        logic [ACC_BITS-1:0] b_part;
        logic [ACC_BITS-1:0] raw;
        logic                sat_now;

        qx     = ACC_BITS'(din.q_val);
        q_part = (din.q_cnt[0] ? qx : '0) + (din.q_cnt[1] ? (qx << 1) : '0);
        a_part = din.a_en ? ACC_BITS'(din.a_val) : '0;
        b_part = din.b_en ? ACC_BITS'(din.b_val) : '0;
        raw    = ACC_BITS'(sum_reg) + q_part + a_part + b_part;
        // no addend is negative, so one clamp at the end matches clamping per glyph
        sat_now   = (raw >= SUM_MAX_ACC);
        total.sum = sat_now ? '1 : raw[SUM_BITS-1:0];
        total.sat = sat_reg || sat_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            sat_reg <= 1'b0;
        end
        else if (step)
        begin
            if (din.last)
            begin
                sum_reg <= '0;
                sat_reg <= 1'b0;
            end
            else
            begin
                sum_reg <= total.sum;
                sat_reg <= total.sat;
            end
        end
    end

    a_sat_pinned: assert property (@(posedge clk) disable iff (!rst_n)
        sat_reg |-> (sum_reg == '1))
        else $error("saturation flag set but sum below maximum");

endmodule

### bench/tb_utf8_text_width_measure_unit.sv
`timescale 1ns / 1ps

// Line width measurement bench.
// A sender process pushes text and table-load beats in bursts, a receiver
// process stalls on its own pattern and checks every result beat against a
// queue of predicted line widths. The predictor below tracks the decode state,
// the advance table and the saturating Q26.6 sum beat by beat.
module tb_utf8_text_width_measure_unit;

    import utf8w_pkg::*;

    // beat kinds on s_tuser
    localparam logic CMD_TEXT = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // characters with special meaning to the decoder
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_QMARK = 8'h3F;

    localparam logic [SUM_BITS:0] SUM_MAX  = {1'b0, {SUM_BITS{1'b1}}};
    localparam logic [SUM_BITS:0] HALF_LSB =
        (FRACTION_BITS > 0) ? ((SUM_BITS + 1)'(1) << (FRACTION_BITS - 1)) : '0;

    localparam int RANDOM_BEATS = 1580;
    localparam int HOLD_CYCLES  = 400;      // long receiver hold-off
    localparam int DRAIN_CYCLES = 20;       // margin after the last result, be generous
    localparam int CYCLE_LIMIT  = 100000;

    typedef struct packed {
        logic [WIDTH_BITS-1:0] px;
        logic                  sat;
    } line_width_t;

    // one directed beat; typed = 1 means the result below is the expectation
    typedef struct packed {
        logic                  cmd;
        logic [7:0]            data_b;
        logic                  eos;
        logic [7:0]            slot;
        logic [ADV_BITS-1:0]   adv;
        logic                  typed;
        logic [WIDTH_BITS-1:0] px;
        logic                  sat;
    } stim_row_t;

    localparam int DIR_ROWS = 25;

    // Loads first pin down the slots the text rows use:
    // slot 0 = 4 px, '?' = 0.5 px, 'A' = 1 px, U+00FF = 0xFFFF (max).
    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        '{CMD_LOAD, 8'h00, 1'b0, 8'd0,   16'h0100, 1'b0, 27'd0,    1'b0},
        '{CMD_LOAD, 8'h00, 1'b0, 8'd31,  16'h0020, 1'b0, 27'd0,    1'b0},
        '{CMD_LOAD, 8'h00, 1'b0, 8'd33,  16'h0040, 1'b0, 27'd0,    1'b0},
        '{CMD_LOAD, 8'h00, 1'b0, 8'd191, 16'hFFFF, 1'b0, 27'd0,    1'b0},
        '{CMD_LOAD, 8'h00, 1'b0, 8'd32,  16'h0000, 1'b0, 27'd0,    1'b0},
        // out of range slots are dropped, end mark on a load means nothing
        '{CMD_LOAD, 8'h00, 1'b0, 8'd192, 16'hFFFF, 1'b0, 27'd0,    1'b0},
        '{CMD_LOAD, 8'h41, 1'b1, 8'd255, 16'h0000, 1'b0, 27'd0,    1'b0},
        // plain ascii
        '{CMD_TEXT, 8'h41, 1'b1, 8'd0,   16'h0000, 1'b1, 27'd1,    1'b0},
        // invalid leads count as '?': 0.5 px rounds up to 1
        '{CMD_TEXT, 8'h80, 1'b1, 8'd0,   16'h0000, 1'b1, 27'd1,    1'b0},
        '{CMD_TEXT, 8'hFF, 1'b1, 8'd0,   16'h0000, 1'b1, 27'd1,    1'b0},
        // U+00FF, max advance
        '{CMD_TEXT, 8'hC3, 1'b0, 8'd0,   16'h0000, 1'b0, 27'd0,    1'b0},
        '{CMD_TEXT, 8'hBF, 1'b1, 8'd0,   16'h0000, 1'b1, 27'd1024, 1'b0},
        // string cut inside a 3 byte sequence: '?' then 'A' again
        '{CMD_TEXT, 8'hE0, 1'b0, 8'd0,   16'h0000, 1'b0, 27'd0,    1'b0},
        '{CMD_TEXT, 8'h41, 1'b1, 8'd0,   16'h0000, 1'b1, 27'd2,    1'b0},
        // CR skipped, LF ends the line, trailing 'A' ignored
        '{CMD_TEXT, 8'h41, 1'b0, 8'd0,   16'h0000, 1'b0, 27'd0,    1'b0},
        '{CMD_TEXT, 8'h0D, 1'b0, 8'd0,   16'h0000, 1'b0, 27'd0,    1'b0},
        '{CMD_TEXT, 8'h0A, 1'b0, 8'd0,   16'h0000, 1'b0, 27'd0,    1'b0},
        '{CMD_TEXT, 8'h41, 1'b1, 8'd0,   16'h0000, 1'b1, 27'd1,    1'b0},
        // overlong LF still ends the line
        '{CMD_TEXT, 8'hC0, 1'b0, 8'd0,   16'h0000, 1'b0, 27'd0,    1'b0},
        '{CMD_TEXT, 8'h8A, 1'b0, 8'd0,   16'h0000, 1'b0, 27'd0,    1'b0},
        '{CMD_TEXT, 8'h41, 1'b1, 8'd0,   16'h0000, 1'b1, 27'd0,    1'b0},
        // 4 byte emoji, no slot of its own -> slot 0
        '{CMD_TEXT, 8'hF0, 1'b0, 8'd0,   16'h0000, 1'b0, 27'd0,    1'b0},
        '{CMD_TEXT, 8'h9F, 1'b0, 8'd0,   16'h0000, 1'b0, 27'd0,    1'b0},
        '{CMD_TEXT, 8'h98, 1'b0, 8'd0,   16'h0000, 1'b0, 27'd0,    1'b0},
        '{CMD_TEXT, 8'h80, 1'b1, 8'd0,   16'h0000, 1'b1, 27'd4,    1'b0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;      // text_byte[7:0], entry_index[15:8], advance_value[31:16]
    logic        s_tuser = 1'b0;    // cmd
    logic        s_tlast = 1'b0;    // end_of_string
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // width_px[26:0], saturated[27]

    utf8_text_width_measure_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the table and the line decoder.
    // ------------------------------------------------------------------
    logic [ADV_BITS-1:0] adv_tbl [TABLE_ENTRIES];
    logic [SUM_BITS-1:0] width_acc = '0;
    logic [7:0]          seq_bytes [4];
    int unsigned         seq_have = 0;     // bytes held of the open sequence
    int unsigned         seq_need = 0;     // 0 = no sequence open
    bit                  line_done = 1'b0; // LF seen
    bit                  sum_clipped = 1'b0;

    line_width_t width_q [$];               // widths still to come out

    int mismatches = 0;
    int cycle_cnt  = 0;
    int burst_left = 0;
    bit hold_req   = 1'b0;
    logic [7:0] line_bytes [$];

    function automatic int unsigned lead_len(input logic [7:0] c);
        if (c < 8'h80)               return 1;
        if ((c & 8'hE0) == 8'hC0)    return 2;
        if ((c & 8'hF0) == 8'hE0)    return 3;
        if ((c & 8'hF8) == 8'hF0)    return 4;
        return 0;
    endfunction

    // codepoint of seq_bytes[at +: len], continuation bits unchecked
    function automatic logic [31:0] join_cp(input int unsigned at, input int unsigned len);
        logic [31:0] cp;
        case (len)
            1:       return {24'd0, seq_bytes[at]};
            2:       cp = {27'd0, seq_bytes[at][4:0]};
            3:       cp = {28'd0, seq_bytes[at][3:0]};
            default: cp = {29'd0, seq_bytes[at][2:0]};
        endcase
        for (int unsigned k = 1; k < len; k++)
            cp = (cp << 6) | {26'd0, seq_bytes[at + k][5:0]};
        return cp;
    endfunction

    function automatic int unsigned slot_of(input logic [31:0] cp);
        if (cp >= 32 && cp < 128)  return cp - 32;
        if (cp >= 160 && cp < 256) return cp - 160 + 96;
        return 0;
    endfunction

    function automatic void add_glyph(input logic [31:0] cp);
        logic [SUM_BITS:0] nxt;
        if (line_done || cp == CHAR_CR)
            return;
        if (cp == CHAR_LF)
        begin
            line_done = 1'b1;
            return;
        end
        nxt = {1'b0, width_acc} + (SUM_BITS + 1)'(adv_tbl[slot_of(cp)]);
        if (nxt >= SUM_MAX)
        begin
            nxt = SUM_MAX;
            sum_clipped = 1'b1;
        end
        width_acc = nxt[SUM_BITS-1:0];
    endfunction

    // string ended mid-sequence: the held bytes are parsed again as a tail
    function automatic void flush_held();
        int unsigned j;
        int unsigned len;
        j = 0;
        while (j < seq_have)
        begin
            len = lead_len(seq_bytes[j]);
            if (len == 0 || j + len > seq_have)
            begin
                add_glyph({24'd0, CHAR_QMARK});
                j++;
            end
            else
            begin
                add_glyph(join_cp(j, len));
                j += len;
            end
        end
    endfunction

    // advance the prediction by one accepted beat; 1 when a width comes out
    function automatic bit measure_beat(input logic cmd, input logic [7:0] c,
                                        input logic eos, input logic [7:0] slot,
                                        input logic [ADV_BITS-1:0] adv,
                                        output line_width_t res);
        int unsigned n;
        logic [SUM_BITS:0] rounded;
        res = '0;
        if (cmd == CMD_LOAD)
        begin
            if (slot < TABLE_ENTRIES)
                adv_tbl[slot] = adv;
            return 1'b0;
        end
        if (!line_done)
        begin
            if (seq_need == 0)
            begin
                n = lead_len(c);
                if (n == 0)
                    add_glyph({24'd0, CHAR_QMARK});
                else if (n == 1)
                    add_glyph({24'd0, c});
                else
                begin
                    seq_bytes[0] = c;
                    seq_have = 1;
                    seq_need = n;
                end
            end
            else
            begin
                seq_bytes[seq_have] = c;
                seq_have++;
                if (seq_have >= seq_need)
                begin
                    add_glyph(join_cp(0, seq_need));
                    seq_have = 0;
                    seq_need = 0;
                end
            end
        end
        if (!eos)
            return 1'b0;
        if (seq_need != 0)
            flush_held();
        rounded = ({1'b0, width_acc} + HALF_LSB) >> FRACTION_BITS;
        res.px  = rounded[WIDTH_BITS-1:0];
        res.sat = sum_clipped;
        width_acc   = '0;
        seq_have    = 0;
        seq_need    = 0;
        line_done   = 1'b0;
        sum_clipped = 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of random length, random gaps in between. Valid is
    // dropped for gaps and drains, so back-to-back beats never toggle it.
    // ------------------------------------------------------------------
    task automatic push_beat(input logic cmd, input logic [7:0] data_b, input logic eos,
                             input logic [7:0] slot, input logic [ADV_BITS-1:0] adv,
                             input bit typed, input line_width_t typed_res);
        int gap;
        line_width_t res;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tlast  <= eos;
        s_tdata  <= {adv, slot, data_b};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (measure_beat(cmd, data_b, eos, slot, adv, res))
            width_q.push_back(typed ? typed_res : res);
    endtask

    task automatic send_text(input logic [7:0] b, input logic eos);
        push_beat(CMD_TEXT, b, eos, 8'd0, '0, 1'b0, '0);
    endtask

    task automatic send_load(input logic [7:0] slot, input logic [ADV_BITS-1:0] adv);
        // random text byte and end mark: both must be ignored on a load
        push_beat(CMD_LOAD, 8'($urandom), 1'($urandom), slot, adv, 1'b0, '0);
    endtask

    // Random line: mostly well-formed UTF-8 of mixed lengths, with control
    // chars, overlong forms, raw noise bytes and a cut-off tail now and then.
    task automatic build_line();
        int nchars;
        int kind;
        int len;
        logic [31:0] cp;
        line_bytes.delete();
        nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 8);
        for (int i = 0; i < nchars; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
                line_bytes.push_back(8'($urandom_range(32, 126)));
            else if (kind < 58)
            begin
                cp = (kind < 50) ? $urandom_range(128, 255) : $urandom_range(128, 16'h7FF);
                line_bytes.push_back({3'b110, cp[10:6]});
                line_bytes.push_back({2'b10, cp[5:0]});
            end
            else if (kind < 64)
            begin
                cp = $urandom_range(16'h800, 16'hFFFF);
                line_bytes.push_back({4'b1110, cp[15:12]});
                line_bytes.push_back({2'b10, cp[11:6]});
                line_bytes.push_back({2'b10, cp[5:0]});
            end
            else if (kind < 68)
            begin
                cp = $urandom_range(32'h10000, 32'h10FFFF);
                line_bytes.push_back({5'b11110, cp[20:18]});
                line_bytes.push_back({2'b10, cp[17:12]});
                line_bytes.push_back({2'b10, cp[11:6]});
                line_bytes.push_back({2'b10, cp[5:0]});
            end
            else if (kind < 71)
                line_bytes.push_back(CHAR_CR);
            else if (kind < 73)
                line_bytes.push_back(CHAR_LF);
            else if (kind < 78)
            begin
                // overlong two byte form of an ascii char, CR and LF included
                cp = (kind < 75) ? ((kind == 73) ? CHAR_LF : CHAR_CR) : $urandom_range(0, 127);
                line_bytes.push_back({3'b110, cp[10:6]});
                line_bytes.push_back({2'b10, cp[5:0]});
            end
            else if (kind < 88)
                line_bytes.push_back(8'($urandom));
            else
                line_bytes.push_back(8'($urandom_range(0, 127)));
        end
        if ($urandom_range(0, 7) == 0)
        begin
            // string ends inside a sequence
            len = $urandom_range(2, 4);
            case (len)
                2:       line_bytes.push_back({3'b110, 5'($urandom)});
                3:       line_bytes.push_back({4'b1110, 4'($urandom)});
                default: line_bytes.push_back({5'b11110, 3'($urandom)});
            endcase
            repeat ($urandom_range(0, len - 2))
                line_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                                   : {2'b10, 6'($urandom)});
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: checks every result beat, ready follows a random mode that is
    // held for a random stretch before the next one, plus one long hold on request.
    // ------------------------------------------------------------------
    int rdy_mode  = 0;
    int mode_left = 0;
    int hold_left = 0;

    always @(posedge clk)
    begin
        line_width_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (width_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result beat px=%0d sat=%0b",
                             $realtime, m_tdata[WIDTH_BITS-1:0], m_tdata[WIDTH_BITS]);
            end
            else
            begin
                want = width_q.pop_front();
                if (m_tdata[WIDTH_BITS-1:0] !== want.px)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: width_px expected %0d got %0d",
                                 $realtime, want.px, m_tdata[WIDTH_BITS-1:0]);
                end
                if (m_tdata[WIDTH_BITS] !== want.sat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: saturated expected %0b got %0b",
                                 $realtime, want.sat, m_tdata[WIDTH_BITS]);
                end
            end
        end

        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rdy_mode  = $urandom_range(0, 3);
                mode_left = $urandom_range(8, 64);
            end
            mode_left--;
            case (rdy_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial
    begin
        int beats;
        bit held_once;
        bit drained_once;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            adv_tbl[i] = '0;
        for (int i = 0; i < 4; i++)
            seq_bytes[i] = '0;
        beats = 0;
        held_once = 1'b0;
        drained_once = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the table is not cleared by reset: load every slot before any text
        for (int i = 0; i < TABLE_ENTRIES; i++)
            send_load(8'(i), 16'($urandom_range(0, 16'h03FF)));

        for (int i = 0; i < DIR_ROWS; i++)
            push_beat(DIRECTED[i].cmd, DIRECTED[i].data_b, DIRECTED[i].eos,
                      DIRECTED[i].slot, DIRECTED[i].adv, DIRECTED[i].typed,
                      '{px: DIRECTED[i].px, sat: DIRECTED[i].sat});

        while (beats < RANDOM_BEATS)
        begin
            if (!held_once && beats > RANDOM_BEATS / 3)
            begin
                // receiver goes quiet while one byte lines keep coming, so
                // the result side backs up into the input
                held_once = 1'b1;
                hold_req = 1'b1;
                for (int i = 0; i < 40; i++)
                    send_text(8'($urandom_range(32, 126)), 1'b1);
                beats += 40;
            end
            if (!drained_once && beats > 2 * RANDOM_BEATS / 3)
            begin
                // sender waits for every pending width before going on
                drained_once = 1'b1;
                s_tvalid <= 1'b0;
                burst_left = 0;
                while (width_q.size() != 0)
                    @(posedge clk);
            end
            build_line();
            for (int i = 0; i < line_bytes.size(); i++)
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    // table update mid-line; slots past the end are dropped
                    send_load(8'($urandom_range(0, 255)),
                              ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 16'h03FF)));
                    beats++;
                end
                send_text(line_bytes[i], i == line_bytes.size() - 1);
                beats++;
            end
        end

        s_tvalid <= 1'b0;
        while (width_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
